### hdl/kvt_pkg.sv
// Shared types and constants of the key/value table with attributes.
// No dependencies; imported by the core and the testbench.
package kvt_pkg;

   localparam int ENTRIES_DEF = 64;
   localparam int KEY_W       = 64;
   localparam int DATA_W      = 64;
   localparam int ATTR_W      = 8;
   localparam int STATUS_W    = 3;
   localparam int USED_W      = 7;
   localparam int USED_MAX    = 127;
   localparam int CSR_IDX_W   = 1;
   localparam int REQ_DATA_W  = 136;
   localparam int RSP_DATA_W  = 72;

   typedef enum logic [1:0] {
      MODE_GET  = 2'd0,
      MODE_PUT  = 2'd1,
      MODE_DEL  = 2'd2,
      MODE_NONE = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_NOT_FOUND = 3'd1,
      ST_READONLY  = 3'd2,
      ST_PROTECTED = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_READONLY_MASK = 1'd0,
      REG_PROTECT_MASK  = 1'd1
   } reg_index_type;

   typedef enum logic [1:0] {
      FSM_CLEAR,
      FSM_IDLE,
      FSM_SCAN,
      FSM_FINISH
   } fsm_type;

   typedef struct packed {
      logic [ATTR_W-1:0] attr;
      logic              valid;
      logic [KEY_W-1:0]  key;
   } tag_type;

   localparam int TAG_W = $bits(tag_type);

endpackage

### hdl/kvt_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module kvt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/key_value_table_with_attributes_core.sv
// One item at a time: a request is accepted only in FSM_IDLE, so no new request is taken
// until the previous result has been loaded into the output register.
// Each item scans the whole tag RAM, one slot per cycle through its read port.
// Reset: synchronous; a clearing pass over every slot zeroes the tag RAM,
// with req_tready low; configuration writes are taken throughout.
// Depends on kvt_pkg and kvt_ram.
module key_value_table_with_attributes_core #(
   parameter int ENTRIES = kvt_pkg::ENTRIES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // req_tdata: key[63:0], data_in[127:64], attr_in[135:128]
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [kvt_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_tuser: mode[1:0]
   input  logic [1:0]                     req_tuser,
   // rsp_tdata: data_out[63:0], used_count[70:64], zero[71]
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [kvt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // rsp_tuser: status[2:0]
   output logic [kvt_pkg::STATUS_W-1:0]   rsp_tuser,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [kvt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [kvt_pkg::ATTR_W-1:0]     csr_data
);
   import kvt_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int TOT_W = (CNT_W > USED_W) ? CNT_W : USED_W;

   fsm_type state_ff, state_in;
   logic [IDX_W:0]       cnt_ff, cnt_in;
   logic                 look_ff, look_in;
   logic [IDX_W-1:0]     look_idx_ff, look_idx_in;
   logic                 hit_ff, hit_in;
   logic [IDX_W-1:0]     hit_idx_ff, hit_idx_in;
   logic [ATTR_W-1:0]    hit_attr_ff, hit_attr_in;
   logic [DATA_W-1:0]    hit_val_ff, hit_val_in;
   logic                 free_ff, free_in;
   logic [IDX_W-1:0]     free_idx_ff, free_idx_in;
   mode_type             mode_ff, mode_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [DATA_W-1:0]    data_ff, data_in;
   logic [ATTR_W-1:0]    attr_ff, attr_in;
   logic [CNT_W-1:0]     total_ff, total_in;
   logic [ATTR_W-1:0]    ro_mask_ff, ro_mask_in;
   logic [ATTR_W-1:0]    pr_mask_ff, pr_mask_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]    rsp_data_ff, rsp_data_in;
   logic [USED_W-1:0]    rsp_used_ff, rsp_used_in;

   logic                 accept;
   logic                 out_free;
   logic                 commit;
   logic                 scan_end;
   logic                 tag_we;
   logic                 val_we;
   logic [IDX_W-1:0]     wr_addr;
   tag_type              tag_wr;
   tag_type              tag_rd;
   logic [TAG_W-1:0]     tag_rd_bits;
   logic [DATA_W-1:0]    val_rd;
   status_type           res_status;
   logic [DATA_W-1:0]    res_data;
   logic [CNT_W-1:0]     res_total;
   logic [TOT_W-1:0]     tot_wide;
   logic                 do_insert;

   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign commit   = (state_ff == FSM_FINISH) && out_free;
   assign scan_end = (cnt_ff == (IDX_W + 1)'(ENTRIES));
   assign tag_rd   = tag_type'(tag_rd_bits);

   assign req_tready = (state_ff == FSM_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {1'b0, rsp_used_ff, rsp_data_ff};

   kvt_ram #(
      .WIDTH(TAG_W),
      .DEPTH(ENTRIES)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_we),
      .wr_addr (wr_addr),
      .wr_data (tag_wr),
      .rd_addr (cnt_ff[IDX_W-1:0]),
      .rd_data (tag_rd_bits)
   );

   kvt_ram #(
      .WIDTH(DATA_W),
      .DEPTH(ENTRIES)
   ) u_val_ram (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (wr_addr),
      .wr_data (data_ff),
      .rd_addr (cnt_ff[IDX_W-1:0]),
      .rd_data (val_rd)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_CLEAR: begin
            if (cnt_ff == (IDX_W + 1)'(ENTRIES - 1)) state_in = FSM_IDLE;
         end
         FSM_IDLE: begin
            if (accept) state_in = FSM_SCAN;
         end
         FSM_SCAN: begin
            if (scan_end) state_in = FSM_FINISH;
         end
         FSM_FINISH: begin
            if (out_free) state_in = FSM_IDLE;
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   // scan and capture
   always_comb begin
      cnt_in      = cnt_ff;
      look_in     = 1'b0;
      look_idx_in = cnt_ff[IDX_W-1:0];
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      hit_attr_in = hit_attr_ff;
      hit_val_in  = hit_val_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      mode_in     = mode_ff;
      key_in      = key_ff;
      data_in     = data_ff;
      attr_in     = attr_ff;
      if (state_ff == FSM_CLEAR) begin
         cnt_in = cnt_ff + 1'b1;
      end
      if (accept) begin
         cnt_in  = '0;
         hit_in  = 1'b0;
         free_in = 1'b0;
         mode_in = mode_type'(req_tuser);
         key_in  = req_tdata[KEY_W-1:0];
         data_in = req_tdata[KEY_W +: DATA_W];
         attr_in = req_tdata[KEY_W + DATA_W +: ATTR_W];
      end
      if (state_ff == FSM_SCAN && !scan_end) begin
         cnt_in  = cnt_ff + 1'b1;
         look_in = 1'b1;
      end
      if (look_ff) begin
         if (tag_rd.valid && tag_rd.key == key_ff && !hit_ff) begin
            hit_in      = 1'b1;
            hit_idx_in  = look_idx_ff;
            hit_attr_in = tag_rd.attr;
            hit_val_in  = val_rd;
         end
         if (!tag_rd.valid && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = look_idx_ff;
         end
      end
   end

   // operation outcome and write-back
   always_comb begin
      res_status = ST_NOT_FOUND;
      res_data   = '0;
      res_total  = total_ff;
      tag_we     = 1'b0;
      val_we     = 1'b0;
      wr_addr    = hit_idx_ff;
      do_insert  = 1'b0;
      tag_wr     = '{attr: attr_ff, valid: 1'b1, key: key_ff};
      if (state_ff == FSM_CLEAR) begin
         tag_we  = 1'b1;
         wr_addr = cnt_ff[IDX_W-1:0];
         tag_wr  = '0;
      end else begin
         unique case (mode_ff)
            MODE_GET: begin
               if (hit_ff) begin
                  res_status = ST_OK;
                  res_data   = hit_val_ff;
               end
            end
            MODE_PUT: begin
               if (hit_ff) begin
                  if ((hit_attr_ff & ro_mask_ff) != '0) begin
                     res_status = ST_READONLY;
                  end else begin
                     res_status = ST_OK;
                     tag_we     = commit;
                     val_we     = commit;
                  end
               end else if (free_ff) begin
                  res_status = ST_OK;
                  do_insert  = 1'b1;
                  wr_addr    = free_idx_ff;
                  tag_we     = commit;
                  val_we     = commit;
                  res_total  = total_ff + 1'b1;
               end else begin
                  res_status = ST_FULL;
               end
            end
            MODE_DEL: begin
               if (hit_ff) begin
                  if ((hit_attr_ff & pr_mask_ff) != '0) begin
                     res_status = ST_PROTECTED;
                  end else begin
                     res_status = ST_OK;
                     tag_wr     = '{attr: hit_attr_ff, valid: 1'b0, key: key_ff};
                     tag_we     = commit;
                     if (total_ff != '0) res_total = total_ff - 1'b1;
                  end
               end
            end
            MODE_NONE: begin
               res_status = ST_NOT_FOUND;
            end
            default: res_status = ST_NOT_FOUND;
         endcase
      end
   end

   assign tot_wide = TOT_W'(res_total);

   always_comb begin
      total_in      = total_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_used_in   = rsp_used_ff;
      ro_mask_in    = ro_mask_ff;
      pr_mask_in    = pr_mask_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (commit) begin
         total_in      = res_total;
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status;
         rsp_data_in   = res_data;
         rsp_used_in   = (tot_wide > TOT_W'(USED_MAX)) ? USED_W'(USED_MAX)
                                                      : tot_wide[USED_W-1:0];
      end
      if (csr_valid && csr_ready) begin
         unique case (reg_index_type'(csr_index))
            REG_READONLY_MASK: ro_mask_in = csr_data;
            REG_PROTECT_MASK:  pr_mask_in = csr_data;
            default:           ro_mask_in = ro_mask_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_CLEAR;
         cnt_ff       <= '0;
         look_ff      <= 1'b0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         total_ff     <= '0;
         ro_mask_ff   <= ATTR_W'(1);
         pr_mask_ff   <= ATTR_W'(2);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         look_ff      <= look_in;
         hit_ff       <= hit_in;
         free_ff      <= free_in;
         total_ff     <= total_in;
         ro_mask_ff   <= ro_mask_in;
         pr_mask_ff   <= pr_mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      look_idx_ff   <= look_idx_in;
      hit_idx_ff    <= hit_idx_in;
      hit_attr_ff   <= hit_attr_in;
      hit_val_ff    <= hit_val_in;
      free_idx_ff   <= free_idx_in;
      mode_ff       <= mode_in;
      key_ff        <= key_in;
      data_ff       <= data_in;
      attr_ff       <= attr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_used_ff   <= rsp_used_in;
   end

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CNT_W'(ENTRIES))
      else $error("entry total exceeds table depth");

   a_write_window: assert property (@(posedge clock) disable iff (reset)
      tag_we |-> (state_ff == FSM_CLEAR || state_ff == FSM_FINISH))
      else $error("tag write outside clear or finish");

   a_insert_free: assert property (@(posedge clock) disable iff (reset)
      (commit && do_insert) |-> (free_ff && !hit_ff))
      else $error("insert without free slot or with existing key");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == FSM_FINISH))
      else $error("result loaded outside finish");

endmodule

### dv/tb_key_value_table_with_attributes_core.sv
// Self-checking bench for key_value_table_with_attributes_core: a directed pass, then random
// get/put/delete/none traffic under several mask settings, checked against a shadow table.
// Depends on kvt_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_key_value_table_with_attributes_core;
   import kvt_pkg::*;

   localparam int              ENTRIES        = ENTRIES_DEF;
   localparam int              QUIET_LIMIT    = 3000;
   localparam int              HOLD_CYCLES    = 300;
   localparam int              POOL_SIZE      = 96;
   localparam logic [ATTR_W-1:0] RO_MASK_RESET  = 8'h01;
   localparam logic [ATTR_W-1:0] DEL_MASK_RESET = 8'h02;

   typedef struct {
      mode_type           op;
      logic [KEY_W-1:0]   key;
      logic [DATA_W-1:0]  data;
      logic [ATTR_W-1:0]  attr;
   } table_op_type;

   typedef struct {
      status_type         status;
      logic [DATA_W-1:0]  data;
      logic [USED_W-1:0]  used;
   } table_answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [1:0]            req_tuser  = MODE_GET;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   reg_index_type         csr_index  = REG_READONLY_MASK;
   logic [ATTR_W-1:0]     csr_data   = '0;

   // shadow copy of the table and its masks
   logic [KEY_W-1:0]  shadow_key  [ENTRIES];
   logic [DATA_W-1:0] shadow_val  [ENTRIES];
   logic [ATTR_W-1:0] shadow_attr [ENTRIES];
   logic              shadow_live [ENTRIES] = '{default: 1'b0};
   int                shadow_count = 0;
   logic [ATTR_W-1:0] ro_mask  = RO_MASK_RESET;
   logic [ATTR_W-1:0] del_mask = DEL_MASK_RESET;

   table_op_type     queued_ops[$];
   table_answer_type table_answers[$];
   logic [KEY_W-1:0] key_pool[POOL_SIZE];

   int   err_count     = 0;
   int   gap_max       = 16;
   int   stall_max     = 16;
   int   req_wait      = 0;
   int   rsp_stall     = 0;
   int   hold_left     = 0;
   int   quiet_cycles  = 0;
   bit   hold_armed    = 1'b0;
   bit   hold_done     = 1'b0;
   bit   req_taken     = 1'b0;
   bit   rsp_taken     = 1'b0;

   key_value_table_with_attributes_core #(.ENTRIES(ENTRIES)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   function automatic void apply_table_op(mode_type op, logic [KEY_W-1:0] k,
                                          logic [DATA_W-1:0] d, logic [ATTR_W-1:0] a);
      table_answer_type ans;
      int            hit;
      int            free_idx;
      hit      = -1;
      free_idx = -1;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (shadow_live[i] && shadow_key[i] == k) hit = i;
         if (!shadow_live[i]) free_idx = i;
      end
      ans.status = ST_NOT_FOUND;
      ans.data   = '0;
      case (op)
         MODE_GET: begin
            if (hit >= 0) begin
               ans.status = ST_OK;
               ans.data   = shadow_val[hit];
            end
         end
         MODE_PUT: begin
            if (hit >= 0) begin
               if ((shadow_attr[hit] & ro_mask) != 0) begin
                  ans.status = ST_READONLY;
               end else begin
                  shadow_val[hit]  = d;
                  shadow_attr[hit] = a;
                  ans.status       = ST_OK;
               end
            end else if (free_idx < 0) begin
               ans.status = ST_FULL;
            end else begin
               shadow_key[free_idx]  = k;
               shadow_val[free_idx]  = d;
               shadow_attr[free_idx] = a;
               shadow_live[free_idx] = 1'b1;
               shadow_count++;
               ans.status = ST_OK;
            end
         end
         MODE_DEL: begin
            if (hit >= 0) begin
               if ((shadow_attr[hit] & del_mask) != 0) begin
                  ans.status = ST_PROTECTED;
               end else begin
                  shadow_live[hit] = 1'b0;
                  if (shadow_count > 0) shadow_count--;
                  ans.status = ST_OK;
               end
            end
         end
         default: begin
         end
      endcase
      ans.used = USED_W'((shadow_count > USED_MAX) ? USED_MAX : shadow_count);
      table_answers.push_back(ans);
   endfunction

   // sample handshakes, predict accepted items, check results
   always @(posedge clock) begin
      table_answer_type want;
      req_taken = !reset && req_tvalid && req_tready;
      rsp_taken = !reset && rsp_tvalid && rsp_tready;
      if (req_taken)
         apply_table_op(mode_type'(req_tuser), req_tdata[63:0], req_tdata[127:64],
                        req_tdata[135:128]);
      if (rsp_taken) begin
         if (table_answers.size() == 0) begin
            $error("result item with no pending lookup: status %0d", rsp_tuser);
            err_count++;
         end else begin
            want = table_answers.pop_front();
            if (rsp_tuser !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_tuser);
               err_count++;
            end
            if (rsp_tdata[63:0] !== want.data) begin
               $error("data_out: expected %h, got %h", want.data, rsp_tdata[63:0]);
               err_count++;
            end
            if (rsp_tdata[70:64] !== want.used) begin
               $error("used_count: expected %0d, got %0d", want.used, rsp_tdata[70:64]);
               err_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_key_value_table_with_attributes_core: errors");
         $finish;
      end
   end

   always @(negedge clock) begin
      table_op_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_taken) begin
         // hold
      end else if (req_wait != 0) begin
         req_tvalid <= 1'b0;
         if (req_tready) req_wait--;
      end else if (queued_ops.size() != 0) begin
         item = queued_ops.pop_front();
         req_tvalid <= 1'b1;
         req_tdata  <= {item.attr, item.data, item.key};
         req_tuser  <= item.op;
         req_wait = $urandom_range(0, gap_max);
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   always @(negedge clock) begin
      if (hold_armed && !hold_done) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end
      if (rsp_taken) rsp_stall = $urandom_range(0, stall_max);
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (rsp_stall != 0) begin
         rsp_tready <= 1'b0;
         if (rsp_tvalid) rsp_stall--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic write_mask(reg_index_type idx, logic [ATTR_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_READONLY_MASK: ro_mask = val;
         REG_PROTECT_MASK:  del_mask = val;
         default: begin
         end
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (queued_ops.size() != 0 || req_tvalid || table_answers.size() != 0)
         @(posedge clock);
   endtask

   function automatic void push_op(mode_type op, logic [KEY_W-1:0] k,
                                   logic [DATA_W-1:0] d, logic [ATTR_W-1:0] a);
      table_op_type item;
      item.op   = op;
      item.key  = k;
      item.data = d;
      item.attr = a;
      queued_ops.push_back(item);
   endfunction

   task automatic run_phase(logic [ATTR_W-1:0] ro, logic [ATTR_W-1:0] prot, int n,
                            int put_pct, int del_pct, int gaps, int stalls, bit squeeze);
      int               r;
      mode_type         op;
      logic [KEY_W-1:0] k;
      wait_idle();
      write_mask(REG_READONLY_MASK, ro);
      write_mask(REG_PROTECT_MASK, prot);
      gap_max   = gaps;
      stall_max = stalls;
      if (squeeze) hold_armed = 1'b1;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < put_pct)                op = MODE_PUT;
         else if (r < put_pct + del_pct) op = MODE_DEL;
         else if (r < 97)                op = MODE_GET;
         else                            op = MODE_NONE;
         if ($urandom_range(0, 9) == 0) k = {$urandom, $urandom};
         else                           k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
         push_op(op, k, {$urandom, $urandom},
                 $urandom_range(0, 1) ? 8'h00 : ATTR_W'($urandom));
      end
      wait_idle();
   endtask

   initial begin
      logic [KEY_W-1:0] k0;
      logic [KEY_W-1:0] k1;
      logic [KEY_W-1:0] k2;
      logic [KEY_W-1:0] k3;
      k0 = '0;
      k1 = '1;
      k2 = 64'h8000_0000_0000_0001;
      k3 = 64'h7FFF_FFFF_FFFF_FFFE;
      key_pool[0] = k0;
      key_pool[1] = k1;
      for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset masks: read-only bit 0, protect bit 1
      push_op(MODE_GET,  k0, '0, 8'h00);
      push_op(MODE_DEL,  k1, '1, 8'hFF);
      push_op(MODE_NONE, k0, '0, 8'h00);
      push_op(MODE_PUT,  k0, '1, 8'h00);
      push_op(MODE_PUT,  k1, '0, 8'hFF);
      push_op(MODE_GET,  k0, '0, 8'h00);
      push_op(MODE_GET,  k1, '1, 8'h00);
      push_op(MODE_PUT,  k1, 64'h123, 8'h00);
      push_op(MODE_DEL,  k1, '0, 8'h00);
      push_op(MODE_NONE, k0, '1, 8'hFF);
      push_op(MODE_PUT,  k0, k2, 8'h80);
      push_op(MODE_GET,  k0, '0, 8'h00);
      push_op(MODE_DEL,  k0, '0, 8'h00);
      push_op(MODE_GET,  k0, '0, 8'h00);
      push_op(MODE_PUT,  k2, k3, 8'h01);
      push_op(MODE_PUT,  k3, k2, 8'h02);
      push_op(MODE_PUT,  k2, '1, 8'h00);
      push_op(MODE_DEL,  k2, '0, 8'h00);
      push_op(MODE_DEL,  k3, '0, 8'h00);
      push_op(MODE_PUT,  k0, 64'h5555_AAAA_5555_AAAA, 8'hFE);
      push_op(MODE_PUT,  k0, 64'hAAAA_5555_AAAA_5555, 8'h00);
      push_op(MODE_DEL,  k0, '0, 8'h00);
      push_op(MODE_GET,  k3, '0, 8'h00);

      run_phase(8'h00, 8'h00, 170, 70, 10, 16, 16, 1'b0);
      run_phase(8'hFF, 8'hFF, 120, 45, 30, 0, 16, 1'b1);
      run_phase(ATTR_W'($urandom), ATTR_W'($urandom), 140, 40, 30, 16, 0, 1'b0);
      run_phase(RO_MASK_RESET, DEL_MASK_RESET, 120, 40, 30, 4, 4, 1'b0);
      run_phase(8'h80, 8'h00, 150, 15, 70, 16, 16, 1'b0);
      run_phase(ATTR_W'($urandom), 8'hFF, 40, 50, 40, 0, 0, 1'b0);

      wait_idle();
      repeat (ENTRIES + 8) @(posedge clock);
      if (err_count == 0 && table_answers.size() == 0) begin
         $display("tb_key_value_table_with_attributes_core: clean");
      end else begin
         $display("tb_key_value_table_with_attributes_core: errors");
      end
      $finish;
   end

endmodule

### files.f
hdl/kvt_pkg.sv
hdl/kvt_ram.sv
hdl/key_value_table_with_attributes_core.sv
dv/tb_key_value_table_with_attributes_core.sv
